[src/vna_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, codes and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    // fixed field widths
    localparam int IDX_W    = 12;
    localparam int IN_POS_W = 20;
    localparam int CFG_W    = 13;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 8;
    localparam int NRM_W    = 16;

    // parameter defaults
    localparam int DEF_MAX_VERTS = 4096;
    localparam int DEF_POS_WIDTH = 20;

    // normal scaling
    localparam int NORM_ONE = 16384;
    localparam int NORM_SH  = 14;
    localparam int CNT_MAX  = 255;

    // squared length below this counts as degenerate (1e-8 * 2^60)
    localparam logic [63:0] SMALL_LEN_SQ_LIMIT = 64'd11529215047;

    // arithmetic widths
    localparam int MAG_W  = 31;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int QUO_W  = 15;
    localparam int NUM_W  = 47;

    // sequencing
    localparam int STEP_W      = 6;
    localparam int COMP_W      = 2;
    localparam int CROSS_STEPS = 6;
    localparam int SQ_STEPS    = 3;
    localparam int SQRT_STEPS  = 32;
    localparam logic [COMP_W-1:0] COMP_LAST = 2'd2;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_TRI   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_WR,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_POS_RD,
        OP_POS_CAP,
        OP_CROSS,
        OP_MAG,
        OP_SHIFT,
        OP_SQ,
        OP_SMALL,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_ACC_RD,
        OP_ACC_WR,
        OP_RD_MEM,
        OP_RD_CAP,
        OP_RD_OUT
    } vna_op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_TRI_RD,
        ST_TRI_CAP,
        ST_CROSS,
        ST_MAG,
        ST_SHIFT,
        ST_SQ,
        ST_CHECK,
        ST_SQRT,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_DONE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_CAP,
        ST_RD_OUT
    } vna_state_t;

    typedef struct packed {
        vna_op_t           op;
        logic [STEP_W-1:0] step;
        logic [COMP_W-1:0] comp;
    } vna_cmd_t;

    typedef struct packed {
        req_t kind;
        logic in_range;
        logic mag_big;
        logic small_len;
        logic clr_done;
        logic out_free;
    } vna_status_t;

endpackage
`default_nettype wire

[src/vna_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/vna_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_datapath
// Position and accumulator memories, cross product, length, divider and
// output register, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
module vna_datapath #(
    parameter int MAX_VERTS = vna_pkg::DEF_MAX_VERTS,
    parameter int POS_WIDTH = vna_pkg::DEF_POS_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire vna_pkg::vna_cmd_t                  cmd,
    output vna_pkg::vna_status_t                    status,
    input  wire logic [1:0]                         req_type,
    input  wire logic [vna_pkg::IDX_W-1:0]          vertex_index_a,
    input  wire logic [vna_pkg::IDX_W-1:0]          vertex_index_b,
    input  wire logic [vna_pkg::IDX_W-1:0]          vertex_index_c,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_x,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_y,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_z,
    input  wire logic                               cfg_wr_en,
    input  wire logic [vna_pkg::CFG_W-1:0]          cfg_wr_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [vna_pkg::IDX_W-1:0]               read_vertex,
    output logic signed [vna_pkg::NRM_W-1:0]        normal_x,
    output logic signed [vna_pkg::NRM_W-1:0]        normal_y,
    output logic signed [vna_pkg::NRM_W-1:0]        normal_z,
    output logic [vna_pkg::CNT_W-1:0]               incident_triangles
);
    import vna_pkg::*;

    localparam int AW        = $clog2(MAX_VERTS);
    localparam int CW        = AW + 1;
    localparam int EW        = POS_WIDTH + 1;
    localparam int PW_P      = 2 * EW;
    localparam int CR_W      = PW_P + 1;
    localparam int POS_RAM_W = 3 * POS_WIDTH;
    localparam int ACC_W     = 3 * SUM_W + CNT_W;

    // captured item
    req_t                       kind_reg;
    logic [IDX_W-1:0]           ia_reg, ib_reg, ic_reg;
    logic signed [IN_POS_W-1:0] px_reg, py_reg, pz_reg;

    logic [CFG_W-1:0]  vcount_reg;
    logic [CW-1:0]     clr_cnt_reg, clr_lim_reg;

    logic [POS_RAM_W-1:0]   pa_reg, pb_reg;
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [PW_P-1:0] prod_reg;
    logic [2:0]             pstep_reg;
    logic signed [CR_W-1:0] cr_reg [3];
    logic [CR_W-1:0]        m_reg [3];
    logic                   neg_reg [3];
    logic                   shifted_reg;
    logic [2*MAG_W-1:0]     sqp_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [SQ_W-1:0]        rv_reg, rr_reg, rb_reg;
    logic [NUM_W-1:0]       rem_reg, dsh_reg;
    logic [QUO_W-1:0]       q_reg;
    logic                   ovf_reg, dneg_reg;
    logic signed [NRM_W-1:0] n_reg [3];
    logic signed [SUM_W-1:0] rs_reg [3];
    logic [CNT_W-1:0]       rc_reg;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        ov_vertex_reg;
    logic signed [NRM_W-1:0] ov_nx_reg, ov_ny_reg, ov_nz_reg;
    logic [CNT_W-1:0]        ov_cnt_reg;

    // memory ports
    logic                 pos_we;
    logic [AW-1:0]        pos_waddr, pos_raddr;
    logic [POS_RAM_W-1:0] pos_wdata, pos_rdata;
    logic                 acc_we;
    logic [AW-1:0]        acc_waddr, acc_raddr;
    logic [ACC_W-1:0]     acc_wdata, acc_rdata, acc_upd;

    logic signed [EW-1:0]   mul_a, mul_b;
    logic [MAG_W-1:0]       m31 [3];
    logic [MAG_W-1:0]       sq_op;
    logic [SQ_W-1:0]        sqrt_t;
    logic [ROOT_W-1:0]      root;
    logic [NUM_W-1:0]       div_num;
    logic [ROOT_W-1:0]      div_den;
    logic                   div_neg;
    logic [QUO_W-1:0]       qcap;
    logic [SUM_W-1:0]       rd_mag;
    logic [CNT_W-1:0]       rd_den;
    logic [IDX_W-1:0]       corner_idx;
    logic                   range_ok;

    function automatic logic idx_ok(input logic [IDX_W-1:0] i);
        return 32'(i) < MAX_VERTS;
    endfunction

    function automatic logic [POS_WIDTH-1:0] sat_pos(input logic signed [IN_POS_W-1:0] v);
        logic signed [33:0] w, hi, lo;
        w  = 34'(v);
        hi = (34'sd1 <<< (POS_WIDTH - 1)) - 34'sd1;
        lo = -(34'sd1 <<< (POS_WIDTH - 1));
        if (w > hi)
        begin
            w = hi;
        end
        if (w < lo)
        begin
            w = lo;
        end
        return w[POS_WIDTH-1:0];
    endfunction

    function automatic logic signed [POS_WIDTH-1:0] coord(input logic [POS_RAM_W-1:0] w,
                                                         input int k);
        return $signed(w[POS_RAM_W-1-k*POS_WIDTH -: POS_WIDTH]);
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s,
                                                 input logic signed [NRM_W-1:0] d);
        logic signed [SUM_W:0] t;
        logic [SUM_W-1:0]      r;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(d);
        if (t[SUM_W] != t[SUM_W-1])
        begin
            r = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            r = t[SUM_W-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- status
    always_comb
    begin
        unique case (kind_reg)
            REQ_TRI:   range_ok = idx_ok(ia_reg) && idx_ok(ib_reg) && idx_ok(ic_reg);
            REQ_CLEAR: range_ok = 1'b1;
            default:   range_ok = idx_ok(ia_reg);
        endcase
    end

    assign status.kind      = kind_reg;
    assign status.in_range  = range_ok;
    assign status.mag_big   = ((m_reg[0] | m_reg[1] | m_reg[2]) >> MAG_W) != '0;
    assign status.small_len = !shifted_reg && (sq_reg < SMALL_LEN_SQ_LIMIT);
    assign status.clr_done  = clr_cnt_reg >= clr_lim_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // ---------------------------------------------------------------- memories
    always_comb
    begin
        unique case (cmd.comp)
            2'd1:    corner_idx = ib_reg;
            2'd2:    corner_idx = ic_reg;
            default: corner_idx = ia_reg;
        endcase
    end

    assign pos_we    = (cmd.op == OP_LOAD_WR);
    assign pos_waddr = AW'(ia_reg);
    assign pos_wdata = {sat_pos(px_reg), sat_pos(py_reg), sat_pos(pz_reg)};
    assign pos_raddr = AW'(corner_idx);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_upd[ACC_W-1-k*SUM_W -: SUM_W] =
                sat_sum($signed(acc_rdata[ACC_W-1-k*SUM_W -: SUM_W]), n_reg[k]);
        end
        acc_upd[CNT_W-1:0] = (acc_rdata[CNT_W-1:0] == CNT_W'(CNT_MAX)) ?
                             acc_rdata[CNT_W-1:0] : acc_rdata[CNT_W-1:0] + 1'b1;
    end

    assign acc_we    = (cmd.op == OP_CLR_STEP) || (cmd.op == OP_ACC_WR);
    assign acc_waddr = (cmd.op == OP_CLR_STEP) ? clr_cnt_reg[AW-1:0] : AW'(corner_idx);
    assign acc_wdata = (cmd.op == OP_CLR_STEP) ? '0 : acc_upd;
    assign acc_raddr = (cmd.op == OP_RD_MEM) ? AW'(ia_reg) : AW'(corner_idx);

    vna_ram #(.WIDTH(POS_RAM_W), .DEPTH(MAX_VERTS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(ACC_W), .DEPTH(MAX_VERTS)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // ---------------------------------------------------------------- arithmetic
    // cross product terms, one product a step
    always_comb
    begin
        unique case (cmd.step[2:0])
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            3'd5:    begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
            default: begin mul_a = '0;        mul_b = '0;        end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m31[k] = MAG_W'(m_reg[k]);
        end
        unique case (cmd.step[1:0])
            2'd1:    sq_op = m31[1];
            2'd2:    sq_op = m31[2];
            default: sq_op = m31[0];
        endcase
    end

    assign sqrt_t = rr_reg + rb_reg;
    assign root   = rr_reg[ROOT_W-1:0];
    assign rd_mag = rs_reg[cmd.comp] < 0 ? SUM_W'(-rs_reg[cmd.comp]) : SUM_W'(rs_reg[cmd.comp]);
    assign rd_den = (rc_reg == '0) ? CNT_W'(1) : rc_reg;

    always_comb
    begin
        if (kind_reg == REQ_TRI)
        begin
            div_num = (NUM_W'(m31[cmd.comp]) << NORM_SH) + NUM_W'(root >> 1);
            div_den = root;
            div_neg = neg_reg[cmd.comp];
        end
        else
        begin
            div_num = NUM_W'(rd_mag) + NUM_W'(rd_den >> 1);
            div_den = ROOT_W'(rd_den);
            div_neg = rs_reg[cmd.comp] < 0;
        end
    end

    assign qcap = (ovf_reg || (q_reg > QUO_W'(NORM_ONE))) ? QUO_W'(NORM_ONE) : q_reg;

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                kind_reg <= req_t'(req_type);
                ia_reg   <= vertex_index_a;
                ib_reg   <= vertex_index_b;
                ic_reg   <= vertex_index_c;
                px_reg   <= pos_x;
                py_reg   <= pos_y;
                pz_reg   <= pos_z;
            end
            OP_POS_CAP:
            begin
                unique case (cmd.comp)
                    2'd0:    pa_reg <= pos_rdata;
                    2'd1:    pb_reg <= pos_rdata;
                    default:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            e1_reg[k] <= EW'(coord(pb_reg, k)) - EW'(coord(pa_reg, k));
                            e2_reg[k] <= EW'(coord(pos_rdata, k)) - EW'(coord(pa_reg, k));
                        end
                    end
                endcase
            end
            OP_CROSS:
            begin
                if (cmd.step < STEP_W'(CROSS_STEPS))
                begin
                    prod_reg  <= mul_a * mul_b;
                    pstep_reg <= cmd.step[2:0];
                end
                // products arrive one step late, odd steps subtract
                if (cmd.step != '0)
                begin
                    unique case (pstep_reg)
                        3'd0:    cr_reg[0] <= CR_W'(prod_reg);
                        3'd1:    cr_reg[0] <= cr_reg[0] - CR_W'(prod_reg);
                        3'd2:    cr_reg[1] <= CR_W'(prod_reg);
                        3'd3:    cr_reg[1] <= cr_reg[1] - CR_W'(prod_reg);
                        3'd4:    cr_reg[2] <= CR_W'(prod_reg);
                        3'd5:    cr_reg[2] <= cr_reg[2] - CR_W'(prod_reg);
                        default: ;
                    endcase
                end
            end
            OP_MAG:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    m_reg[k]   <= cr_reg[k] < 0 ? CR_W'(-cr_reg[k]) : CR_W'(cr_reg[k]);
                    neg_reg[k] <= cr_reg[k] < 0;
                end
                shifted_reg <= 1'b0;
            end
            OP_SHIFT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    m_reg[k] <= m_reg[k] >> 1;
                end
                shifted_reg <= 1'b1;
            end
            OP_SQ:
            begin
                if (cmd.step < STEP_W'(SQ_STEPS))
                begin
                    sqp_reg <= sq_op * sq_op;
                end
                if (cmd.step == STEP_W'(1))
                begin
                    sq_reg <= SQ_W'(sqp_reg);
                end
                else if (cmd.step != '0)
                begin
                    sq_reg <= sq_reg + SQ_W'(sqp_reg);
                end
            end
            OP_SMALL:
            begin
                // round q.30 to q1.14, half away from zero
                for (int k = 0; k < 3; k++)
                begin
                    n_reg[k] <= neg_reg[k] ?
                        -NRM_W'((32'(m31[k]) + 32'd32768) >> 16) :
                         NRM_W'((32'(m31[k]) + 32'd32768) >> 16);
                end
            end
            OP_SQRT_INIT:
            begin
                rv_reg <= sq_reg;
                rr_reg <= '0;
                rb_reg <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQRT_STEP:
            begin
                if (rv_reg >= sqrt_t)
                begin
                    rv_reg <= rv_reg - sqrt_t;
                    rr_reg <= (rr_reg >> 1) + rb_reg;
                end
                else
                begin
                    rr_reg <= rr_reg >> 1;
                end
                rb_reg <= rb_reg >> 2;
            end
            OP_DIV_LOAD:
            begin
                ovf_reg  <= div_num >= (NUM_W'(div_den) << QUO_W);
                rem_reg  <= div_num;
                dsh_reg  <= NUM_W'(div_den) << (QUO_W - 1);
                q_reg    <= '0;
                dneg_reg <= div_neg;
            end
            OP_DIV_STEP:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[QUO_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_DIV_DONE:
            begin
                n_reg[cmd.comp] <= dneg_reg ? -NRM_W'(qcap) : NRM_W'(qcap);
            end
            OP_RD_CAP:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rs_reg[k] <= $signed(acc_rdata[ACC_W-1-k*SUM_W -: SUM_W]);
                end
                rc_reg <= acc_rdata[CNT_W-1:0];
            end
            OP_RD_OUT:
            begin
                ov_vertex_reg <= ia_reg;
                ov_nx_reg     <= range_ok ? n_reg[0] : '0;
                ov_ny_reg     <= range_ok ? n_reg[1] : '0;
                ov_nz_reg     <= range_ok ? n_reg[2] : '0;
                ov_cnt_reg    <= range_ok ? rc_reg : '0;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            vcount_reg    <= '0;
            clr_cnt_reg   <= '0;
            // sweep the whole accumulator store after reset
            clr_lim_reg   <= CW'(MAX_VERTS);
        end
        else
        begin
            if (cmd.op == OP_RD_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_CLR_START)
            begin
                clr_cnt_reg <= '0;
                clr_lim_reg <= (32'(vcount_reg) > MAX_VERTS) ? CW'(MAX_VERTS) : CW'(vcount_reg);
            end
            else if (cmd.op == OP_CLR_STEP)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign read_vertex        = ov_vertex_reg;
    assign normal_x           = ov_nx_reg;
    assign normal_y           = ov_ny_reg;
    assign normal_z           = ov_nz_reg;
    assign incident_triangles = ov_cnt_reg;

endmodule
`default_nettype wire

[src/vna_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_ctrl
// Sequencer: walks each item one step a cycle; reads wait for out_free.
// ----------------------------------------------------------------------------
module vna_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire vna_pkg::vna_status_t status,
    output vna_pkg::vna_cmd_t         cmd
);
    import vna_pkg::*;

    vna_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [COMP_W-1:0] comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        comp_next  = comp_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        cmd.comp   = comp_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op = OP_CLR_STEP;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                step_next = '0;
                comp_next = '0;
                unique case (status.kind)
                    REQ_LOAD:
                    begin
                        if (status.in_range)
                        begin
                            cmd.op = OP_LOAD_WR;
                        end
                        state_next = ST_IDLE;
                    end
                    REQ_TRI:
                    begin
                        state_next = status.in_range ? ST_TRI_RD : ST_IDLE;
                    end
                    REQ_READ:
                    begin
                        if (status.in_range)
                        begin
                            cmd.op     = OP_RD_MEM;
                            state_next = ST_RD_CAP;
                        end
                        else
                        begin
                            state_next = ST_RD_OUT;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.op     = OP_CLR_START;
                        state_next = ST_CLEAR;
                    end
                endcase
            end
            ST_TRI_RD:
            begin
                cmd.op     = OP_POS_RD;
                state_next = ST_TRI_CAP;
            end
            ST_TRI_CAP:
            begin
                cmd.op = OP_POS_CAP;
                if (comp_reg == COMP_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_CROSS;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_TRI_RD;
                end
            end
            ST_CROSS:
            begin
                cmd.op    = OP_CROSS;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CROSS_STEPS))
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // bring all magnitudes below 2^31 before squaring
                if (status.mag_big)
                begin
                    cmd.op = OP_SHIFT;
                end
                else
                begin
                    step_next  = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.op    = OP_SQ;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQ_STEPS))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                step_next = '0;
                comp_next = '0;
                if (status.small_len)
                begin
                    cmd.op     = OP_SMALL;
                    state_next = ST_ACC_RD;
                end
                else
                begin
                    cmd.op     = OP_SQRT_INIT;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.op    = OP_SQRT_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.op     = OP_DIV_LOAD;
                step_next  = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.op    = OP_DIV_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:
            begin
                cmd.op = OP_DIV_DONE;
                if (comp_reg == COMP_LAST)
                begin
                    comp_next  = '0;
                    state_next = (status.kind == REQ_TRI) ? ST_ACC_RD : ST_RD_OUT;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_ACC_RD:
            begin
                cmd.op     = OP_ACC_RD;
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR:
            begin
                // next corner is read only after this write lands
                cmd.op = OP_ACC_WR;
                if (comp_reg == COMP_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_ACC_RD;
                end
            end
            ST_RD_CAP:
            begin
                cmd.op     = OP_RD_CAP;
                comp_next  = '0;
                state_next = ST_DIV_LOAD;
            end
            ST_RD_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_RD_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/vertex_normal_accumulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Per-vertex normal averaging for a triangle mesh.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_ready is high only while the sequencer
// is idle, and a finished read waits in the output register while the next
// item is taken. A read runs three 15-step restoring divisions on one shared
// divider. A triangle runs s right shifts (s = shifts needed to bring the
// cross product under 2^31), the 32-step square root and the three
// divisions; a degenerate triangle skips the root and divisions. A clear
// zeroes min(vertex_count, MAX_VERTS) accumulator entries, one entry a
// cycle. After reset the accumulator store is swept before the first item
// is accepted; configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
    parameter int MAX_VERTS = vna_pkg::DEF_MAX_VERTS,
    parameter int POS_WIDTH = vna_pkg::DEF_POS_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          req_type,
    input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_a,
    input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_b,
    input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_c,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_x,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_y,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [vna_pkg::IDX_W-1:0]                read_vertex,
    output logic signed [vna_pkg::NRM_W-1:0]         normal_x,
    output logic signed [vna_pkg::NRM_W-1:0]         normal_y,
    output logic signed [vna_pkg::NRM_W-1:0]         normal_z,
    output logic [vna_pkg::CNT_W-1:0]                incident_triangles,
    input  wire logic                                cfg_wr_en,
    input  wire logic [vna_pkg::CFG_W-1:0]           cfg_wr_data
);
    import vna_pkg::*;

    vna_cmd_t    cmd;
    vna_status_t status;

    vna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    vna_datapath #(
        .MAX_VERTS (MAX_VERTS),
        .POS_WIDTH (POS_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .req_type           (req_type),
        .vertex_index_a     (vertex_index_a),
        .vertex_index_b     (vertex_index_b),
        .vertex_index_c     (vertex_index_c),
        .pos_x              (pos_x),
        .pos_y              (pos_y),
        .pos_z              (pos_z),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .read_vertex        (read_vertex),
        .normal_x           (normal_x),
        .normal_y           (normal_y),
        .normal_z           (normal_z),
        .incident_triangles (incident_triangles)
    );

endmodule
`default_nettype wire

[test/vna_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vna_checker
// Watches the request, result and register ports of the vertex normal
// accumulator, keeps its own copy of positions, normal sums and counts, and
// compares every returned normal with the one it worked out for that read.
// ----------------------------------------------------------------------------
module vna_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic [1:0]                          req_type,
    input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_a,
    input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_b,
    input  wire logic [vna_pkg::IDX_W-1:0]           vertex_index_c,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_x,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_y,
    input  wire logic signed [vna_pkg::IN_POS_W-1:0] pos_z,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic [vna_pkg::IDX_W-1:0]           read_vertex,
    input  wire logic signed [vna_pkg::NRM_W-1:0]    normal_x,
    input  wire logic signed [vna_pkg::NRM_W-1:0]    normal_y,
    input  wire logic signed [vna_pkg::NRM_W-1:0]    normal_z,
    input  wire logic [vna_pkg::CNT_W-1:0]           incident_triangles,
    input  wire logic                                cfg_wr_en,
    input  wire logic [vna_pkg::CFG_W-1:0]           cfg_wr_data,
    output int                                       fail_count,
    output int                                       normals_pending
);
    import vna_pkg::*;

    localparam int VERTS = DEF_MAX_VERTS;

    typedef struct {
        logic [IDX_W-1:0] vertex;
        logic [NRM_W-1:0] nx;
        logic [NRM_W-1:0] ny;
        logic [NRM_W-1:0] nz;
        logic [CNT_W-1:0] tris;
    } avg_normal_t;

    longint      px [VERTS];
    longint      py [VERTS];
    longint      pz [VERTS];
    int          sum_x [VERTS];
    int          sum_y [VERTS];
    int          sum_z [VERTS];
    int          tri_cnt [VERTS];
    int          clear_len;
    avg_normal_t normals_due [$];

    initial fail_count = 0;

    function automatic int sat_sum(longint v);
        if (v > 64'sd8388607) return 8388607;
        if (v < -64'sd8388608) return -8388608;
        return int'(v);
    endfunction

    function automatic bit [63:0] int_root(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [NRM_W-1:0] mean_component(int sum, int cnt);
        longint d;
        longint mag;
        longint q;
        d = (cnt < 1) ? 1 : cnt;
        mag = (sum < 0) ? -longint'(sum) : longint'(sum);
        q = (mag + d / 2) / d;
        if (q > NORM_ONE) q = NORM_ONE;
        if (sum < 0) q = -q;
        return q[NRM_W-1:0];
    endfunction

    function automatic void add_corner(int v, int n [3]);
        sum_x[v] = sat_sum(longint'(sum_x[v]) + n[0]);
        sum_y[v] = sat_sum(longint'(sum_y[v]) + n[1]);
        sum_z[v] = sat_sum(longint'(sum_z[v]) + n[2]);
        if (tri_cnt[v] < CNT_MAX) tri_cnt[v]++;
    endfunction

    function automatic void add_face(int a, int b, int c);
        longint    e1x, e1y, e1z, e2x, e2y, e2z;
        longint    cr [3];
        bit [63:0] m [3];
        bit [63:0] mx;
        bit [63:0] sq;
        bit [63:0] len;
        bit [63:0] q;
        int        n [3];
        int        s;
        e1x = px[b] - px[a];
        e1y = py[b] - py[a];
        e1z = pz[b] - pz[a];
        e2x = px[c] - px[a];
        e2y = py[c] - py[a];
        e2z = pz[c] - pz[a];
        cr[0] = e1y * e2z - e1z * e2y;
        cr[1] = e1z * e2x - e1x * e2z;
        cr[2] = e1x * e2y - e1y * e2x;
        for (int i = 0; i < 3; i++) m[i] = (cr[i] < 0) ? -cr[i] : cr[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        s = 0;
        while ((mx >> s) >= 64'h8000_0000) s++;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> s;
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        // degenerate face: raw product rounded to Q1.14
        if (s == 0 && sq < SMALL_LEN_SQ_LIMIT)
        begin
            for (int i = 0; i < 3; i++) n[i] = int'((m[i] + 32768) >> 16);
        end
        else
        begin
            len = int_root(sq);
            for (int i = 0; i < 3; i++)
            begin
                q = (m[i] * NORM_ONE + len / 2) / len;
                if (q > NORM_ONE) q = NORM_ONE;
                n[i] = int'(q);
            end
        end
        for (int i = 0; i < 3; i++) if (cr[i] < 0) n[i] = -n[i];
        add_corner(a, n);
        add_corner(b, n);
        add_corner(c, n);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_normal_t e;
        int          a;
        if (!rst_n)
        begin
            for (int v = 0; v < VERTS; v++)
            begin
                px[v] = 0;
                py[v] = 0;
                pz[v] = 0;
                sum_x[v] = 0;
                sum_y[v] = 0;
                sum_z[v] = 0;
                tri_cnt[v] = 0;
            end
            clear_len = 0;
            normals_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (normals_due.size() == 0)
                begin
                    $display("%0t: unexpected normal item, expected none, actual vertex %0d",
                             $time, read_vertex);
                    fail_count++;
                end
                else
                begin
                    e = normals_due.pop_front();
                    check_field("read_vertex", longint'(e.vertex), longint'(read_vertex));
                    check_field("normal_x", longint'($signed(e.nx)), longint'(normal_x));
                    check_field("normal_y", longint'($signed(e.ny)), longint'(normal_y));
                    check_field("normal_z", longint'($signed(e.nz)), longint'(normal_z));
                    check_field("incident_triangles", longint'(e.tris),
                                longint'(incident_triangles));
                end
            end
            if (cfg_wr_en) clear_len = int'(cfg_wr_data);
            if (in_valid && in_ready)
            begin
                a = int'(vertex_index_a);
                case (req_t'(req_type))
                    REQ_LOAD:
                    begin
                        px[a] = longint'(pos_x);
                        py[a] = longint'(pos_y);
                        pz[a] = longint'(pos_z);
                    end
                    REQ_TRI: add_face(a, int'(vertex_index_b), int'(vertex_index_c));
                    REQ_CLEAR:
                    begin
                        for (int v = 0; v < VERTS && v < clear_len; v++)
                        begin
                            sum_x[v] = 0;
                            sum_y[v] = 0;
                            sum_z[v] = 0;
                            tri_cnt[v] = 0;
                        end
                    end
                    default:
                    begin
                        e.vertex = vertex_index_a;
                        e.nx = mean_component(sum_x[a], tri_cnt[a]);
                        e.ny = mean_component(sum_y[a], tri_cnt[a]);
                        e.nz = mean_component(sum_z[a], tri_cnt[a]);
                        e.tris = CNT_W'(tri_cnt[a]);
                        normals_due = {normals_due, e};
                    end
                endcase
            end
        end
        normals_pending = normals_due.size();
    end

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives loads, triangles, reads and clears into the vertex normal
// accumulator under random idling on both sides and several clear lengths;
// a separate checker predicts every averaged normal and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import vna_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     SETTLE      = 4400;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  req_type;
    logic [IDX_W-1:0]            vertex_index_a;
    logic [IDX_W-1:0]            vertex_index_b;
    logic [IDX_W-1:0]            vertex_index_c;
    logic signed [IN_POS_W-1:0]  pos_x;
    logic signed [IN_POS_W-1:0]  pos_y;
    logic signed [IN_POS_W-1:0]  pos_z;
    logic                        out_valid;
    logic                        out_ready;
    logic [IDX_W-1:0]            read_vertex;
    logic signed [NRM_W-1:0]     normal_x;
    logic signed [NRM_W-1:0]     normal_y;
    logic signed [NRM_W-1:0]     normal_z;
    logic [CNT_W-1:0]            incident_triangles;
    logic                        cfg_wr_en;
    logic [CFG_W-1:0]            cfg_wr_data;
    int                          fail_count;
    int                          normals_pending;

    longint cycle_count;
    bit     no_gaps;
    bit     long_hold;
    bit     loaded [DEF_MAX_VERTS];
    int     loaded_list [$];

    vertex_normal_accumulator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .vertex_index_a(vertex_index_a), .vertex_index_b(vertex_index_b),
        .vertex_index_c(vertex_index_c),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_ready(out_ready), .read_vertex(read_vertex),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .incident_triangles(incident_triangles),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    vna_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .vertex_index_a(vertex_index_a), .vertex_index_b(vertex_index_b),
        .vertex_index_c(vertex_index_c),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_ready(out_ready), .read_vertex(read_vertex),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .incident_triangles(incident_triangles),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .normals_pending(normals_pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall per item, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(negedge clk);
        wait (rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready = 1'b0;
                repeat (3000) @(negedge clk);
                long_hold = 0;
            end
            else if (!no_gaps)
            begin
                int gap;
                gap = $urandom_range(0, 16);
                if (gap > 0)
                begin
                    out_ready = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ready = 1'b1;
            while (!out_valid) @(negedge clk);
            @(negedge clk);
        end
    end

    task automatic send(req_t kind, int a, int b, int c, int x, int y, int z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type = kind;
        vertex_index_a = IDX_W'(a);
        vertex_index_b = IDX_W'(b);
        vertex_index_c = IDX_W'(c);
        pos_x = IN_POS_W'(x);
        pos_y = IN_POS_W'(y);
        pos_z = IN_POS_W'(z);
        in_valid = 1'b1;
        while (!in_ready) @(negedge clk);
        @(negedge clk);
        if (kind == REQ_LOAD && !loaded[a])
        begin
            loaded[a] = 1;
            loaded_list = {loaded_list, a};
        end
    endtask

    task automatic set_clear_len(int n);
        in_valid = 1'b0;
        while (normals_pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = CFG_W'(n);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 8) - 4;
            1: return $urandom_range(0, 1) ? 524287 : -524288;
            default: return int'($signed(20'($urandom)));
        endcase
    endfunction

    function automatic int pick_loaded();
        if (loaded_list.size() > 32 && $urandom_range(0, 9) < 7)
            return loaded_list[$urandom_range(0, 31)];
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    task automatic random_items(int count);
        int a, b, c, r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                a = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31)
                                               : $urandom_range(0, DEF_MAX_VERTS - 1);
                send(REQ_LOAD, a, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     rand_coord(), rand_coord(), rand_coord());
            end
            else if (r < 70)
            begin
                a = pick_loaded();
                b = pick_loaded();
                c = pick_loaded();
                // repeated corners now and then
                if ($urandom_range(0, 9) == 0) b = a;
                send(REQ_TRI, a, b, c, rand_coord(), rand_coord(), rand_coord());
            end
            else if (r < 95)
            begin
                a = ($urandom_range(0, 1)) ? pick_loaded() : $urandom_range(0, 4095);
                send(REQ_READ, a, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     rand_coord(), rand_coord(), rand_coord());
            end
            else
                send(REQ_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        int clear_lens [7];
        clear_lens = '{0, 4096, 37, 1, 300, 4095, 8191};
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_LOAD;
        vertex_index_a = '0;
        vertex_index_b = '0;
        vertex_index_c = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        no_gaps = 0;
        long_hold = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        cfg_wr_en = 1'b1;
        cfg_wr_data = 13'd8191;
        @(negedge clk);
        cfg_wr_en = 1'b0;

        // extremes, degenerate and repeated-corner faces, clear then reread
        send(REQ_LOAD, 0, 0, 0, -524288, 524287, -524288);
        send(REQ_LOAD, 4095, 4095, 4095, 524287, -524288, 524287);
        send(REQ_LOAD, 1, 0, 0, 0, 0, 0);
        send(REQ_LOAD, 2, 0, 0, 1, 0, 0);
        send(REQ_LOAD, 3, 0, 0, 0, 1, 0);
        send(REQ_LOAD, 4, 0, 0, 524287, 0, 0);
        send(REQ_LOAD, 5, 0, 0, 0, 524287, 0);
        send(REQ_TRI, 1, 2, 3, 0, 0, 0);
        send(REQ_TRI, 1, 4, 5, 0, 0, 0);
        send(REQ_TRI, 0, 4095, 1, 0, 0, 0);
        send(REQ_TRI, 1, 1, 2, 0, 0, 0);
        send(REQ_TRI, 4095, 0, 5, 0, 0, 0);
        send(REQ_READ, 1, 0, 0, 0, 0, 0);
        send(REQ_READ, 4, 0, 0, 0, 0, 0);
        send(REQ_READ, 5, 0, 0, 0, 0, 0);
        send(REQ_READ, 0, 4095, 4095, -524288, -524288, -524288);
        send(REQ_READ, 4095, 0, 0, 0, 0, 0);
        send(REQ_READ, 2, 0, 0, 0, 0, 0);
        send(REQ_READ, 3000, 0, 0, 0, 0, 0);
        send(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
        send(REQ_READ, 1, 0, 0, 0, 0, 0);
        send(REQ_TRI, 1, 4, 5, 0, 0, 0);
        send(REQ_READ, 4, 0, 0, 0, 0, 0);

        // result side stalls while reads keep coming
        long_hold = 1;
        for (int i = 0; i < 6; i++) send(REQ_READ, i, 0, 0, 0, 0, 0);

        // count and sum saturation on one face
        send(REQ_LOAD, 100, 0, 0, 0, 0, 0);
        send(REQ_LOAD, 101, 0, 0, 262144, 0, 0);
        send(REQ_LOAD, 102, 0, 0, 0, 262144, 0);
        for (int i = 0; i < 530; i++)
        begin
            no_gaps = (i % 100) < 30;
            send(REQ_TRI, 100, 101, 102, 0, 0, 0);
        end
        no_gaps = 0;
        send(REQ_READ, 100, 0, 0, 0, 0, 0);
        send(REQ_READ, 102, 0, 0, 0, 0, 0);

        foreach (clear_lens[p])
        begin
            set_clear_len(clear_lens[p]);
            for (int j = 0; j < 4; j++)
            begin
                no_gaps = (j == 2);
                random_items(25);
            end
            no_gaps = 0;
        end

        in_valid = 1'b0;
        while (normals_pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
